// File: rtl/core/lbd_pkg.sv
`timescale 1ns / 1ps

package lbd_pkg;

	// Configuration register width and reset value
	localparam int CFG_W = 11;
	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// Label word
	localparam int LABEL_W = 32;

	// Sign taps of one window row, as seen at the current word:
	// row is the oldest-but-two, d1 and d2 follow one and two words later in age
	typedef struct packed {
		logic row;
		logic d1;
		logic d2;
	} lbd_taps_t;

endpackage

// File: rtl/core/lbd_line_cell.sv
`timescale 1ns / 1ps

module lbd_line_cell #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic [$clog2(MAX_WIDTH+1)-1:0] line_len,
	input  logic                           in_bit,
	input  logic                           in_d1,
	output lbd_pkg::lbd_taps_t             taps
);
	import lbd_pkg::*;

	localparam int LW    = $clog2(MAX_WIDTH + 1);
	localparam int DEPTH = (MAX_WIDTH > 1) ? MAX_WIDTH - 1 : 1;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic          mem [DEPTH];
	logic          rd_q;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] ptr_e;
	logic [LW-1:0] len_m1;
	logic [LW-1:0] ptr_inc;
	logic          row_bit;
	logic          d1_q;
	logic          d2_q;

	// Ring of line_len-1 entries plus the read register delays by one full line
	assign len_m1  = line_len - LW'(1);
	// A pointer left beyond a shortened line restarts at the first entry
	assign ptr_e   = (LW'(ptr_q) >= len_m1) ? '0 : ptr_q;
	assign ptr_inc = LW'(ptr_e) + LW'(1);

	// One-pixel lines have no ring: the line delay is the upstream one-word tap
	assign row_bit = (line_len == LW'(1)) ? in_d1 : rd_q;

	// Advance the ring pointer, wrap at the line length minus one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (adv) begin
			if (ptr_inc >= len_m1) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= AW'(ptr_inc);
			end
		end
	end

	// Read the old bit, then overwrite it with the incoming one
	always_ff @(posedge clk) begin
		if (adv) begin
			rd_q         <= mem[ptr_e];
			mem[ptr_e]   <= in_bit;
		end
	end

	// Shift the row taps
	always_ff @(posedge clk) begin
		if (adv) begin
			d1_q <= row_bit;
			d2_q <= d1_q;
		end
	end

	assign taps = '{row: row_bit, d1: d1_q, d2: d2_q};

endmodule

// File: rtl/core/label_boundary_detect_3x3.sv
`timescale 1ns / 1ps

// 3x3 boundary marker for a raster label stream. Each accepted word carries one signed
// label; only its sign is kept. A frame is frame_height*frame_width pixel words followed
// by frame_width+1 drain words whose label is ignored. The word at raster position k
// delivers the result for pixel k-(frame_width+1), so the first frame_width+1 words of a
// frame give no result and every later word gives exactly one. boundary is 1 when the
// pixel's label is non-negative and at least one in-frame 8-neighbor is negative;
// last_pixel flags the final pixel of the frame, after which a new frame starts. The block
// takes one word per clock when not stalled: each of the two line delays is a one-bit
// memory read and written once per word, and the window is a chain of two line cells plus
// two sign taps. A result sits in an output register and the input is stalled only while
// that register is full and stalled. Write frame_width / frame_height (zero acts as 1,
// values above MAX_WIDTH / MAX_HEIGHT act as the maximum) only between frames.
module label_boundary_detect_3x3 #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  px_valid,
	output logic                                  px_stall,
	input  logic signed [lbd_pkg::LABEL_W-1:0]    label,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output logic                                  boundary,
	output logic                                  last_pixel,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lbd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lbd_pkg::CFG_W-1:0]             cfg_data
);
	import lbd_pkg::*;

	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int WH   = $clog2(MAX_HEIGHT + 1);
	localparam int CLW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CMPW = ((CFG_W > WW) ? ((CFG_W > WH) ? CFG_W : WH)
	                                    : ((WW > WH) ? WW : WH)) + 1;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [WW-1:0]    eff_w;
	logic [WH-1:0]    eff_h;

	logic [CLW-1:0]   in_col_q;
	logic [CFG_W-1:0] in_row_q;
	logic [CLW-1:0]   out_col_q;
	logic [CFG_W-1:0] out_row_q;

	logic             acc;
	logic             cur;
	logic             emit;
	logic             in_col_wrap;
	logic             top_ok;
	logic             bot_ok;
	logic             left_ok;
	logic             right_ok;
	logic             last_c;
	logic             hit;
	logic             boundary_c;

	logic             x1_q;
	logic             x2_q;
	lbd_taps_t        mid_taps;
	lbd_taps_t        up_taps;

	logic             res_valid_q;
	logic             boundary_q;
	logic             last_q;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_RESET;
			height_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Clamp sizes into 1..MAX
	always_comb begin
		if (width_q == '0) begin
			eff_w = WW'(1);
		end else if (CMPW'(width_q) > CMPW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(width_q);
		end
		if (height_q == '0) begin
			eff_h = WH'(1);
		end else if (CMPW'(height_q) > CMPW'(MAX_HEIGHT)) begin
			eff_h = WH'(MAX_HEIGHT);
		end else begin
			eff_h = WH'(height_q);
		end
	end

	// Input handshake: hold off only while a result waits and is stalled
	assign px_stall = res_valid_q && res_stall;
	assign acc      = px_valid && !px_stall;

	// Drain words store a clear sign
	assign cur  = (CMPW'(in_row_q) < CMPW'(eff_h)) ? label[LABEL_W-1] : 1'b0;
	assign emit = (in_row_q >= CFG_W'(2)) || ((in_row_q == CFG_W'(1)) && (in_col_q != '0));
	assign in_col_wrap = (CMPW'(in_col_q) + CMPW'(1)) >= CMPW'(eff_w);

	// Neighbor presence inside the frame
	assign top_ok   = (out_row_q != '0);
	assign bot_ok   = (CMPW'(out_row_q) + CMPW'(1)) < CMPW'(eff_h);
	assign left_ok  = (out_col_q != '0);
	assign right_ok = (CMPW'(out_col_q) + CMPW'(1)) < CMPW'(eff_w);
	assign last_c   = !bot_ok && !right_ok;

	// Newest row taps
	always_ff @(posedge clk) begin
		if (acc) begin
			x1_q <= cur;
			x2_q <= x1_q;
		end
	end

	// Line cells: middle row (one line back) and upper row (two lines back)
	lbd_line_cell #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_cell_mid (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (acc),
		.line_len(eff_w),
		.in_bit  (cur),
		.in_d1   (x1_q),
		.taps    (mid_taps)
	);

	lbd_line_cell #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_cell_up (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (acc),
		.line_len(eff_w),
		.in_bit  (mid_taps.row),
		.in_d1   (mid_taps.d1),
		.taps    (up_taps)
	);

	// OR the in-frame neighbors; the center is mid_taps.d1
	assign hit = (top_ok && left_ok && up_taps.d2) || (top_ok && up_taps.d1) ||
	             (top_ok && right_ok && up_taps.row) ||
	             (left_ok && mid_taps.d2) || (right_ok && mid_taps.row) ||
	             (bot_ok && left_ok && x2_q) || (bot_ok && x1_q) ||
	             (bot_ok && right_ok && cur);
	assign boundary_c = hit && !mid_taps.d1;

	// Advance raster counters, restart after the last pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (acc) begin
			if (emit && last_c) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (emit) begin
					if (!right_ok) begin
						out_col_q <= '0;
						if (out_row_q != '1) begin
							out_row_q <= out_row_q + CFG_W'(1);
						end
					end else begin
						out_col_q <= out_col_q + CLW'(1);
					end
				end
				if (in_col_wrap) begin
					in_col_q <= '0;
					if (in_row_q != '1) begin
						in_row_q <= in_row_q + CFG_W'(1);
					end
				end else begin
					in_col_q <= in_col_q + CLW'(1);
				end
			end
		end
	end

	// Output register: load on an emitting word, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (acc && emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && emit) begin
			boundary_q <= boundary_c;
			last_q     <= last_c;
		end
	end

	assign res_valid  = res_valid_q;
	assign boundary   = boundary_q;
	assign last_pixel = last_q;

	// The reported column stays inside the line
	a_out_col_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(out_col_q) < CMPW'(eff_w))
		else $error("output column outside the line");

	// The input position runs at least one row ahead of the reported pixel
	a_in_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && emit) |-> (in_row_q > out_row_q))
		else $error("input position not ahead of output position");

	// The frame restarts after the last pixel
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && emit && last_c) |=> (in_row_q == '0 && in_col_q == '0 && out_row_q == '0))
		else $error("counters not cleared after the last pixel");

endmodule

// File: tb/sv/label_boundary_detect_3x3_tb.sv
`timescale 1ns / 1ps

module label_boundary_detect_3x3_tb;
	import lbd_pkg::*;

	localparam int MAX_W        = 1024;
	localparam int MAX_H        = 1024;
	localparam int RING_DEPTH   = 2 * MAX_W;
	localparam int IDLE_LIMIT   = 20000;
	localparam int HOLD_CYCLES  = 300;
	localparam int ITEM_TARGET  = 1030;
	localparam int DIR_ROWS     = 23;

	typedef enum bit {ROW_WORD, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
		logic [LABEL_W-1:0]   lbl;
		bit                   typed;
		bit                   boundary;
		bit                   last;
	} dir_row_t;

	typedef struct packed {
		bit boundary;
		bit last;
	} mark_t;

	logic                      clk        = 1'b0;
	logic                      arst_n     = 1'b0;
	logic                      px_valid   = 1'b0;
	logic                      px_stall;
	logic signed [LABEL_W-1:0] label      = '0;
	logic                      res_valid;
	logic                      res_stall  = 1'b0;
	logic                      boundary;
	logic                      last_pixel;
	logic                      cfg_valid  = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index  = '0;
	logic [CFG_W-1:0]          cfg_data   = '0;

	// Boundary predictor state
	logic [CFG_W-1:0] width_reg  = CFG_RESET;
	logic [CFG_W-1:0] height_reg = CFG_RESET;
	bit               sign_ring [RING_DEPTH];
	bit [8:0]         win_signs  = '0;
	int               in_col     = 0;
	int               in_row     = 0;
	int               out_col    = 0;
	int               out_row    = 0;

	mark_t pending_marks [$];
	int    mismatches    = 0;
	int    send_idle_pct = 0;
	int    stall_pct     = 0;
	bit    hold_req      = 1'b0;
	int    idle_cycles   = 0;

	// Directed words: a 3x3 frame with label extremes, then one-pixel frames from zero sizes
	dir_row_t dir_tab [DIR_ROWS] = '{
		'{ROW_CFG,  REG_FRAME_WIDTH,  11'd3, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
		'{ROW_CFG,  REG_FRAME_HEIGHT, 11'd3, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
		'{ROW_WORD, 1'b0, 11'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0},
		'{ROW_WORD, 1'b0, 11'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
		'{ROW_WORD, 1'b0, 11'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
		'{ROW_WORD, 1'b0, 11'd0, 32'h8000_0000, 1'b0, 1'b0, 1'b0},
		'{ROW_WORD, 1'b0, 11'd0, 32'h0000_0005, 1'b0, 1'b0, 1'b0},
		'{ROW_WORD, 1'b0, 11'd0, 32'h0000_0007, 1'b0, 1'b0, 1'b0},
		'{ROW_WORD, 1'b0, 11'd0, 32'h0000_0001, 1'b0, 1'b0, 1'b0},
		'{ROW_WORD, 1'b0, 11'd0, 32'h0000_0002, 1'b0, 1'b0, 1'b0},
		'{ROW_WORD, 1'b0, 11'd0, 32'h0000_0003, 1'b0, 1'b0, 1'b0},
		// drain words carry negative labels that must be ignored
		'{ROW_WORD, 1'b0, 11'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
		'{ROW_WORD, 1'b0, 11'd0, 32'h8000_0000, 1'b0, 1'b0, 1'b0},
		'{ROW_WORD, 1'b0, 11'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
		'{ROW_WORD, 1'b0, 11'd0, 32'h8000_0000, 1'b0, 1'b0, 1'b0},
		'{ROW_CFG,  REG_FRAME_WIDTH,  11'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
		'{ROW_CFG,  REG_FRAME_HEIGHT, 11'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
		// lone pixel has no neighbor, so it is never a boundary
		'{ROW_WORD, 1'b0, 11'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0},
		'{ROW_WORD, 1'b0, 11'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
		'{ROW_WORD, 1'b0, 11'd0, 32'h8000_0000, 1'b1, 1'b0, 1'b1},
		'{ROW_WORD, 1'b0, 11'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
		'{ROW_WORD, 1'b0, 11'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
		'{ROW_WORD, 1'b0, 11'd0, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1}
	};

	label_boundary_detect_3x3 #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.px_valid  (px_valid),
		.px_stall  (px_stall),
		.label     (label),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.boundary  (boundary),
		.last_pixel(last_pixel),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Map a size register onto the range the block honors
	function automatic int clamp_size(logic [CFG_W-1:0] v, int max_v);
		if (v == 0)
			return 1;
		if (int'(v) > max_v)
			return max_v;
		return int'(v);
	endfunction

	// Sign of the pixel d words back from the current one
	function automatic bit sign_back(int d, bit cur, int s0, int w);
		int slot;
		if (d == 0)
			return cur;
		if (d >= 1 && d <= 2 * w) begin
			slot = (s0 >= d) ? s0 - d : s0 + 2 * w - d;
			if (slot < 0 || slot >= RING_DEPTH)
				return 1'b0;
			return sign_ring[slot];
		end
		if (d == 2 * w + 1)
			return win_signs[0];
		if (d == 2 * w + 2)
			return win_signs[1];
		return 1'b0;
	endfunction

	// Advance the predictor by one accepted word
	task automatic mark_boundary(input logic [LABEL_W-1:0] lbl, output bit has_mark,
			output mark_t m);
		int w, h, s0, rr, cc, d;
		bit cur, hit;
		w = clamp_size(width_reg, MAX_W);
		h = clamp_size(height_reg, MAX_H);
		cur = (in_row < h) ? lbl[LABEL_W-1] : 1'b0;
		s0 = (in_row % 2) * w + in_col;
		has_mark = (in_row >= 2) || (in_row == 1 && in_col >= 1);
		if (s0 >= 2 * w)
			s0 = 0;
		m = '0;
		if (has_mark) begin
			hit = 1'b0;
			for (int dr = -1; dr <= 1; dr++) begin
				for (int dc = -1; dc <= 1; dc++) begin
					rr = out_row + dr;
					cc = out_col + dc;
					if (rr < 0) rr = 0;
					if (rr > h - 1) rr = h - 1;
					if (cc < 0) cc = 0;
					if (cc > w - 1) cc = w - 1;
					if (rr != out_row || cc != out_col) begin
						d = (out_row - rr) * w + (out_col - cc) + w + 1;
						hit |= sign_back(d, cur, s0, w);
					end
				end
			end
			// an unlabelled center is never a boundary
			if (sign_back(w + 1, cur, s0, w))
				hit = 1'b0;
			m.boundary = hit;
			m.last = (out_row + 1 >= h) && (out_col + 1 >= w);
		end
		win_signs = {win_signs[7:0], sign_ring[s0]};
		sign_ring[s0] = cur;
		if (has_mark && m.last) begin
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
		end else begin
			if (has_mark) begin
				if (out_col + 1 >= w) begin
					out_col = 0;
					if (out_row < 2047) out_row++;
				end else begin
					out_col++;
				end
			end
			if (in_col + 1 >= w) begin
				in_col = 0;
				if (in_row < 2047) in_row++;
			end else begin
				in_col++;
			end
		end
	endtask

	// Offer one word, hold it until taken, then queue its expected mark
	task automatic send_word(input logic [LABEL_W-1:0] lbl, input bit typed,
			input mark_t typed_m);
		bit    has_mark;
		mark_t m;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			px_valid <= 1'b0;
			@(posedge clk);
		end
		px_valid <= 1'b1;
		label <= lbl;
		do @(posedge clk); while (px_stall);
		mark_boundary(lbl, has_mark, m);
		if (has_mark)
			pending_marks.insert(pending_marks.size(), typed ? typed_m : m);
	endtask

	// Write a size register once the block has drained
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		px_valid <= 1'b0;
		while (pending_marks.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_FRAME_WIDTH)
			width_reg = data;
		else
			height_reg = data;
	endtask

	// Check taken results and drive the result stall
	initial begin : result_sink
		int    hold_left;
		mark_t want;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) begin
				if (pending_marks.size() == 0) begin
					$error("unexpected result: boundary=%0b last_pixel=%0b",
						boundary, last_pixel);
					mismatches++;
				end else begin
					want = pending_marks.pop_front();
					if (boundary !== want.boundary) begin
						$error("boundary: expected %0b, got %0b", want.boundary, boundary);
						mismatches++;
					end
					if (last_pixel !== want.last) begin
						$error("last_pixel: expected %0b, got %0b", want.last, last_pixel);
						mismatches++;
					end
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else begin
				res_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Abort when no word moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (px_valid && !px_stall) || (res_valid && !res_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[label_boundary_detect_3x3] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		dir_row_t           row;
		int                 w_set, h_set, frame_w, frame_h, bias, frame_no, sent_items;
		bit                 press, noise;
		logic [LABEL_W-1:0] lbl;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table at full rate
		foreach (dir_tab[i]) begin
			row = dir_tab[i];
			if (row.kind == ROW_CFG)
				write_reg(row.idx, row.data);
			else
				send_word(row.lbl, row.typed, mark_t'{row.boundary, row.last});
		end

		// Random frames, rotating through the idling phases
		sent_items = 0;
		for (frame_no = 0; frame_no < 4 || sent_items < ITEM_TARGET; frame_no++) begin
			case (frame_no % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 68; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 68; end
				default: begin send_idle_pct = 35; stall_pct = 35; end
			endcase
			press = 1'b0;
			if (frame_no == 4) begin
				w_set = 20;
				h_set = 6;
				press = 1'b1;
			end else begin
				w_set = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40)
					: $urandom_range(0, 12);
				h_set = $urandom_range(0, 9);
			end
			write_reg(REG_FRAME_WIDTH, w_set[CFG_W-1:0]);
			write_reg(REG_FRAME_HEIGHT, h_set[CFG_W-1:0]);
			frame_w = clamp_size(width_reg, MAX_W);
			frame_h = clamp_size(height_reg, MAX_H);
			bias = $urandom_range(0, 100);
			noise = ($urandom_range(0, 4) == 0);
			for (int k = 0; k < frame_h * frame_w + frame_w + 1; k++) begin
				// stall the result side while the input keeps coming
				if (press && k == frame_w + 2)
					hold_req = 1'b1;
				lbl = $urandom;
				if (!noise && k < frame_h * frame_w)
					lbl[LABEL_W-1] = ($urandom_range(0, 99) < bias);
				send_word(lbl, 1'b0, '0);
			end
			sent_items += frame_w * frame_h + frame_w + 1;
		end

		// Drain and report
		px_valid <= 1'b0;
		while (pending_marks.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[label_boundary_detect_3x3] OK");
		else
			$display("[label_boundary_detect_3x3] ERROR");
		$finish;
	end

endmodule
